[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("Assertion failed: same-cycle implication.");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("Assertion failed: next-cycle implication.");

`endif

[rtl/lpbd_pkg.sv]
// ---------------------------------------------------------------------------
// LED pixel buffer package
// Types and constants shared by the pixel buffer delta engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpbd_pkg;

  localparam int LED_COUNT  = 256;
  localparam int LED_ADDR_W = $clog2(LED_COUNT);
  localparam int LEN_W      = 9;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [LEN_W-1:0] LED_COUNT_LEN = LEN_W'(LED_COUNT);
  localparam logic [23:0]      BASE_RESET    = 24'hFF_FFFF;

  typedef logic [LED_ADDR_W-1:0] led_addr_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } color_t;

  typedef enum logic [2:0] {
    OP_FILL      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_BASE      = 3'd2,
    OP_INTENSITY = 3'd3,
    OP_DELTA     = 3'd4,
    OP_READ      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCALE,
    ST_FILL
  } state_t;

endpackage

[rtl/lpbd_if.sv]
// ---------------------------------------------------------------------------
// LED pixel buffer channel interfaces
// Command and response channels with a valid/ready handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpbd_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [7:0]        led_index;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic signed [7:0] delta_intensity;
  logic signed [7:0] delta_red;
  logic signed [7:0] delta_green;
  logic signed [7:0] delta_blue;

  modport source (
    output valid, op, led_index, red, green, blue,
           delta_intensity, delta_red, delta_green, delta_blue,
    input  ready
  );
  modport sink (
    input  valid, op, led_index, red, green, blue,
           delta_intensity, delta_red, delta_green, delta_blue,
    output ready
  );
endinterface

interface lpbd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_index;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (
    output valid, out_index, out_red, out_green, out_blue,
    input  ready
  );
  modport sink (
    input  valid, out_index, out_red, out_green, out_blue,
    output ready
  );
endinterface

[rtl/lpbd_scale.sv]
// ---------------------------------------------------------------------------
// LED intensity scaler
// Registers level * base per channel, then divides each product by 255.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpbd_scale (
  input  logic                 clk,
  input  logic                 load,
  input  logic [7:0]           level,
  input  lpbd_pkg::color_t     base,
  output lpbd_pkg::color_t     scaled
);

  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;

  // Exact floor(x / 255) for any x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + {8'h00, x[15:8]} + 16'd1;
    return t[15:8];
  endfunction

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= 16'(level) * 16'(base.r);
      prod_g <= 16'(level) * 16'(base.g);
      prod_b <= 16'(level) * 16'(base.b);
    end
  end

  assign scaled.r = div255(prod_r);
  assign scaled.g = div255(prod_g);
  assign scaled.b = div255(prod_b);

endmodule

[rtl/led_pixel_buffer_delta_engine.sv]
// ---------------------------------------------------------------------------
// LED pixel buffer delta engine
// Frame buffer of colour, base colour and intensity per LED with delta ops.
// ---------------------------------------------------------------------------
// One command is handled at a time. A write, set-base, colour delta, read or
// zero intensity change first reads the LED's entries from the synchronous
// colour and base/intensity memories, then modifies, writes back and loads
// the response register, waiting while it holds a response not yet taken. A
// non-zero intensity change in the strip adds a step, as the per-channel
// multiply by the base colour is registered before the divide by 255. A fill
// writes the colour memory one LED per cycle over the strip length, then
// loads the response. A response may wait in its output register while the
// next command is taken. After reset is released a clearing pass writes the
// reset base colour and a zero intensity into every base/intensity memory
// entry, and no command is taken until it ends. Per-LED valid bits make
// colours read as zero after reset and beyond a shortened strip.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module led_pixel_buffer_delta_engine (
  input  logic                            clk,
  input  logic                            rst,
  lpbd_cmd_if.sink                        cmd,
  lpbd_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpbd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lpbd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lpbd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  lpbd_pkg::state_t state;
  lpbd_pkg::state_t state_next;

  logic [lpbd_pkg::LEN_W-1:0] strip_length;
  logic [lpbd_pkg::LEN_W-1:0] eff_len;
  logic [lpbd_pkg::LEN_W-1:0] new_len;
  logic [lpbd_pkg::LEN_W-1:0] fill_cnt;
  logic                       cfg_write;

  // Memories and the colour valid bits.
  lpbd_pkg::color_t           led_mem [lpbd_pkg::LED_COUNT];
  logic [31:0]                aux_mem [lpbd_pkg::LED_COUNT];
  logic [lpbd_pkg::LED_COUNT-1:0] led_valid;
  lpbd_pkg::color_t           led_rd;
  logic [31:0]                aux_rd;
  logic                       led_rd_vld;

  logic                       led_we;
  lpbd_pkg::led_addr_t        led_wa;
  lpbd_pkg::color_t           led_wd;
  logic                       aux_we;
  lpbd_pkg::led_addr_t        aux_wa;
  logic [31:0]                aux_wd;
  logic                       init_busy;
  lpbd_pkg::led_addr_t        init_cnt;

  // Captured command.
  lpbd_pkg::op_t              op_q;
  logic [7:0]                 idx_q;
  lpbd_pkg::color_t           col_q;
  logic signed [7:0]          di_q;
  logic signed [7:0]          dr_q;
  logic signed [7:0]          dg_q;
  logic signed [7:0]          db_q;

  logic                       accept;
  logic                       out_free;
  logic                       in_strip;
  logic                       go_scale;
  lpbd_pkg::color_t           cur_led;
  lpbd_pkg::color_t           cur_base;
  logic [7:0]                 cur_lvl;
  logic [7:0]                 new_lvl;
  lpbd_pkg::color_t           delta_col;
  lpbd_pkg::color_t           scaled;
  logic                       scale_load;

  logic                       res_load;
  logic [7:0]                 res_idx;
  lpbd_pkg::color_t           res_col;
  logic                       rsp_valid;
  logic [7:0]                 rsp_index;
  lpbd_pkg::color_t           rsp_col;

  function automatic logic [7:0] sat8(input logic [7:0] v, input logic signed [7:0] d);
    logic signed [9:0] s;
    s = $signed({2'b00, v}) + $signed({{2{d[7]}}, d});
    if (s < 10'sd0) begin
      return 8'd0;
    end else if (s > 10'sd255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  // Configuration port.
  assign pready    = 1'b1;
  assign prdata    = {{(lpbd_pkg::APB_DATA_W - lpbd_pkg::LEN_W){1'b0}}, strip_length};
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign new_len   = (pwdata[8:0] > lpbd_pkg::LED_COUNT_LEN) ? lpbd_pkg::LED_COUNT_LEN
                                                             : pwdata[8:0];
  assign eff_len   = (strip_length > lpbd_pkg::LED_COUNT_LEN) ? lpbd_pkg::LED_COUNT_LEN
                                                              : strip_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_length <= lpbd_pkg::LED_COUNT_LEN;
    end else if (cfg_write) begin
      strip_length <= pwdata[8:0];
    end
  end

  // Clearing pass over the base/intensity memory after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_busy <= 1'b1;
      init_cnt  <= '0;
    end else if (init_busy) begin
      init_cnt <= init_cnt + 1'b1;
      if (init_cnt == lpbd_pkg::led_addr_t'(lpbd_pkg::LED_COUNT - 1)) begin
        init_busy <= 1'b0;
      end
    end
  end

  // Handshake.
  assign cmd.ready = (state == lpbd_pkg::ST_IDLE) && !init_busy;
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= lpbd_pkg::op_t'(cmd.op);
      idx_q <= cmd.led_index;
      col_q <= '{r: cmd.red, g: cmd.green, b: cmd.blue};
      di_q  <= cmd.delta_intensity;
      dr_q  <= cmd.delta_red;
      dg_q  <= cmd.delta_green;
      db_q  <= cmd.delta_blue;
    end
  end

  // Colour memory and base/intensity memory, with registered reads.
  always_ff @(posedge clk) begin
    if (led_we) begin
      led_mem[led_wa] <= led_wd;
    end
    if (accept) begin
      led_rd <= led_mem[cmd.led_index];
    end
  end

  always_ff @(posedge clk) begin
    if (aux_we) begin
      aux_mem[aux_wa] <= aux_wd;
    end
    if (accept) begin
      aux_rd <= aux_mem[cmd.led_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_valid <= '0;
    end else begin
      if (led_we) begin
        led_valid[led_wa] <= 1'b1;
      end
      if (cfg_write) begin
        for (int i = 0; i < lpbd_pkg::LED_COUNT; i++) begin
          if (lpbd_pkg::LEN_W'(i) >= new_len) begin
            led_valid[i] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      led_rd_vld <= led_valid[cmd.led_index];
    end
  end

  // Current entry and updated values.
  assign cur_led  = led_rd_vld ? led_rd : '0;
  assign cur_base = lpbd_pkg::color_t'(aux_rd[31:8]);
  assign cur_lvl  = aux_rd[7:0];
  assign new_lvl  = sat8(cur_lvl, di_q);
  assign in_strip = {1'b0, idx_q} < eff_len;
  assign go_scale = (op_q == lpbd_pkg::OP_INTENSITY) && in_strip && (di_q != 8'sd0);

  assign delta_col.r = sat8(cur_led.r, dr_q);
  assign delta_col.g = sat8(cur_led.g, dg_q);
  assign delta_col.b = sat8(cur_led.b, db_q);

  lpbd_scale u_scale (
    .clk    (clk),
    .load   (scale_load),
    .level  (new_lvl),
    .base   (cur_base),
    .scaled (scaled)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lpbd_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (lpbd_pkg::op_t'(cmd.op) == lpbd_pkg::OP_FILL) ? lpbd_pkg::ST_FILL
                                                                     : lpbd_pkg::ST_LOOKUP;
        end
      end
      lpbd_pkg::ST_LOOKUP: begin
        if (go_scale) begin
          state_next = lpbd_pkg::ST_SCALE;
        end else if (out_free) begin
          state_next = lpbd_pkg::ST_IDLE;
        end
      end
      lpbd_pkg::ST_SCALE: begin
        if (out_free) begin
          state_next = lpbd_pkg::ST_IDLE;
        end
      end
      lpbd_pkg::ST_FILL: begin
        if ((fill_cnt == eff_len) && out_free) begin
          state_next = lpbd_pkg::ST_IDLE;
        end
      end
      default: state_next = lpbd_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    led_we     = 1'b0;
    led_wa     = idx_q;
    led_wd     = col_q;
    aux_we     = 1'b0;
    aux_wa     = idx_q;
    aux_wd     = {cur_base, cur_lvl};
    scale_load = 1'b0;
    res_load   = 1'b0;
    res_idx    = idx_q;
    res_col    = '0;
    case (state)
      lpbd_pkg::ST_LOOKUP: begin
        if (go_scale) begin
          aux_we     = 1'b1;
          aux_wd     = {cur_base, new_lvl};
          scale_load = 1'b1;
        end else if (out_free) begin
          res_load = 1'b1;
          case (op_q)
            lpbd_pkg::OP_WRITE: begin
              if (in_strip) begin
                led_we  = 1'b1;
                res_col = col_q;
              end
            end
            lpbd_pkg::OP_BASE: begin
              if ({1'b0, idx_q} < lpbd_pkg::LED_COUNT_LEN) begin
                aux_we  = 1'b1;
                aux_wd  = {col_q, cur_lvl};
                res_col = col_q;
              end
            end
            lpbd_pkg::OP_INTENSITY: begin
              res_col = in_strip ? cur_led : '0;
            end
            lpbd_pkg::OP_DELTA: begin
              if (in_strip) begin
                led_we  = 1'b1;
                led_wd  = delta_col;
                res_col = delta_col;
              end
            end
            lpbd_pkg::OP_READ: begin
              res_col = in_strip ? cur_led : '0;
            end
            default: res_col = '0;
          endcase
        end
      end
      lpbd_pkg::ST_SCALE: begin
        if (out_free) begin
          led_we   = 1'b1;
          led_wd   = scaled;
          res_load = 1'b1;
          res_col  = scaled;
        end
      end
      lpbd_pkg::ST_FILL: begin
        if (fill_cnt < eff_len) begin
          led_we = 1'b1;
          led_wa = fill_cnt[lpbd_pkg::LED_ADDR_W-1:0];
        end else if (out_free) begin
          res_load = 1'b1;
          res_idx  = 8'd0;
          res_col  = col_q;
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
    if (init_busy) begin
      aux_we = 1'b1;
      aux_wa = init_cnt;
      aux_wd = {lpbd_pkg::BASE_RESET, 8'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lpbd_pkg::ST_IDLE;
      fill_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == lpbd_pkg::ST_IDLE) begin
        fill_cnt <= '0;
      end else if ((state == lpbd_pkg::ST_FILL) && (fill_cnt < eff_len)) begin
        fill_cnt <= fill_cnt + 1'b1;
      end
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp_index <= res_idx;
      rsp_col   <= res_col;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.out_index = rsp_index;
  assign rsp.out_red   = rsp_col.r;
  assign rsp.out_green = rsp_col.g;
  assign rsp.out_blue  = rsp_col.b;

  `ASSERT_NEXT(a_accept_starts_work, clk, rst, accept, state == lpbd_pkg::ST_LOOKUP || state == lpbd_pkg::ST_FILL)
  `ASSERT_IMPLY(a_fill_within_len, clk, rst, state == lpbd_pkg::ST_FILL, fill_cnt <= eff_len)
  `ASSERT_IMPLY(a_rsp_from_work, clk, rst, $rose(rsp_valid), $past(state) != lpbd_pkg::ST_IDLE)
  `ASSERT_IMPLY(a_no_accept_in_init, clk, rst, init_busy, !accept)

endmodule
